### hw/rtl/pbe_pkg.sv
// shared widths, constants, stage sideband type and fixed-point helpers
// for the particle boundary pipeline; no dependencies
package pbe_pkg;

  localparam int FIELD_W   = 20;             // signed Q3.16 payload
  localparam int DAMP_W    = 17;             // unsigned Q1.16
  localparam int SCALE_W   = 18;             // unsigned Q2.16
  localparam int DELTA_W   = FIELD_W + 1;    // offset from the circle center
  localparam int SQ_W      = 40;             // one squared offset
  localparam int SUM_W     = SQ_W + 1;       // sum of squares
  localparam int ROOT_W    = 28;             // distance, Q.24
  localparam int RAD_W     = 2 * ROOT_W;     // radicand
  localparam int REM_W     = ROOT_W + 2;     // square root remainder
  localparam int MAG_W     = 20;             // magnitude of one offset
  localparam int NUM_W     = MAG_W + 25;     // dividend of the normal
  localparam int QUO_W     = 17;             // normal magnitude
  localparam int NORM_W    = QUO_W + 1;      // signed normal, Q.16
  localparam int ONE_Q16   = 65536;
  localparam int HALF_Q16  = 32768;

  localparam logic SHAPE_RECT = 1'b1;
  localparam logic EDGE_WRAP  = 1'b1;

  typedef enum logic [1:0] {
    REG_DAMPING = 2'd0,
    REG_SHAPE   = 2'd1,
    REG_EDGE    = 2'd2,
    REG_SCALE   = 2'd3
  } reg_idx_e;

  // what an item carries alongside the square root and divider
  typedef struct packed {
    logic                       refl;      // circle reflect result wanted
    logic [FIELD_W-1:0]         byp_px;
    logic [FIELD_W-1:0]         byp_py;
    logic [FIELD_W-1:0]         byp_vx;
    logic [FIELD_W-1:0]         byp_vy;
    logic signed [DELTA_W-1:0]  dx;
    logic signed [DELTA_W-1:0]  dy;
    logic signed [FIELD_W-1:0]  vx;
    logic signed [FIELD_W-1:0]  vy;
  } side_t;

  // round to nearest, ties toward plus infinity
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int unsigned s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat20(input logic signed [63:0] v);
    if (v > 64'sd524287) begin
      return 20'h7FFFF;
    end else if (v < -64'sd524288) begin
      return 20'h80000;
    end
    return v[FIELD_W-1:0];
  endfunction

endpackage

### hw/rtl/pbe_norm_div.sv
// pipelined restoring divider that turns the center offset and distance
// into the signed unit normal, one quotient bit per stage; uses pbe_pkg
module pbe_norm_div import pbe_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  side_t                     side_i,
  input  logic [ROOT_W-1:0]         root_i,
  output logic                      valid_o,
  output side_t                     side_o,
  output logic signed [NORM_W-1:0]  norm_x_o,
  output logic signed [NORM_W-1:0]  norm_y_o
);

  logic               vld_q  [QUO_W+1];
  side_t              side_q [QUO_W+1];
  logic [NUM_W-1:0]   rx_q   [QUO_W+1];
  logic [NUM_W-1:0]   ry_q   [QUO_W+1];
  logic [NUM_W-1:0]   den_q  [QUO_W+1];
  logic [QUO_W-1:0]   qx_q   [QUO_W+1];
  logic [QUO_W-1:0]   qy_q   [QUO_W+1];

  logic [DELTA_W-1:0] abs_x, abs_y;
  logic               vld_out_q;
  side_t              side_out_q;
  logic signed [NORM_W-1:0] nx_q, ny_q;

  assign abs_x = side_i.dx[DELTA_W-1] ? DELTA_W'(-side_i.dx) : DELTA_W'(side_i.dx);
  assign abs_y = side_i.dy[DELTA_W-1] ? DELTA_W'(-side_i.dy) : DELTA_W'(side_i.dy);

  // dividend with half the divisor added for rounding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    rx_q[0]   <= NUM_W'({abs_x[MAG_W-1:0], 24'b0}) + NUM_W'(root_i >> 1);
    ry_q[0]   <= NUM_W'({abs_y[MAG_W-1:0], 24'b0}) + NUM_W'(root_i >> 1);
    den_q[0]  <= NUM_W'(root_i);
    qx_q[0]   <= '0;
    qy_q[0]   <= '0;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [NUM_W-1:0] trial;
    logic             ge_x, ge_y;

    assign trial = den_q[k] << (QUO_W - 1 - k);
    assign ge_x  = rx_q[k] >= trial;
    assign ge_y  = ry_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k+1] <= side_q[k];
      den_q[k+1]  <= den_q[k];
      rx_q[k+1]   <= ge_x ? rx_q[k] - trial : rx_q[k];
      ry_q[k+1]   <= ge_y ? ry_q[k] - trial : ry_q[k];
      qx_q[k+1]   <= {qx_q[k][QUO_W-2:0], ge_x};
      qy_q[k+1]   <= {qy_q[k][QUO_W-2:0], ge_y};
    end
  end

  // sign of the offset goes back on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    side_out_q <= side_q[QUO_W];
    nx_q <= side_q[QUO_W].dx[DELTA_W-1] ? -$signed({1'b0, qx_q[QUO_W]})
                                        :  $signed({1'b0, qx_q[QUO_W]});
    ny_q <= side_q[QUO_W].dy[DELTA_W-1] ? -$signed({1'b0, qy_q[QUO_W]})
                                        :  $signed({1'b0, qy_q[QUO_W]});
  end

  assign valid_o  = vld_out_q;
  assign side_o   = side_out_q;
  assign norm_x_o = nx_q;
  assign norm_y_o = ny_q;

endmodule

### hw/rtl/particle_boundary_enforce_core.sv
// top level of the particle boundary pipeline: register port, input stage,
// square root, normal divider and reflection math; uses pbe_pkg, pbe_norm_div
//
// Enforces the domain boundary on one particle per clock. A transfer is
// taken at every rising edge with start high; busy is always low, so items
// may be issued back to back without gaps. Each result is driven in input
// order on the new_* ports for one cycle with done_o high; the receiver
// must take it then. The pipeline holds the bit-serial square root
// (28 stages, one root bit each) and the normal divider (17 stages, one
// quotient bit each), plus the multiply stages around them. Registers are
// written over the APB port (damping at 0x0, shape at 0x4, edge mode at
// 0x8, scale at 0xC) and must only change while no item is in flight,
// since every stage that uses them reads them live.
module particle_boundary_enforce_core import pbe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // item input
  input  logic                start,
  output logic                busy,
  input  logic [FIELD_W-1:0]  pos_x_i,
  input  logic [FIELD_W-1:0]  pos_y_i,
  input  logic [FIELD_W-1:0]  vel_x_i,
  input  logic [FIELD_W-1:0]  vel_y_i,
  // result output
  output logic                done_o,
  output logic [FIELD_W-1:0]  new_pos_x_o,
  output logic [FIELD_W-1:0]  new_pos_y_o,
  output logic [FIELD_W-1:0]  new_vel_x_o,
  output logic [FIELD_W-1:0]  new_vel_y_o
);

  // ---------------------------------------------------------------------
  // register file
  // ---------------------------------------------------------------------
  logic [DAMP_W-1:0]  damp_q;
  logic               shape_q;
  logic               edge_q;
  logic [SCALE_W-1:0] scale_q;
  logic               cfg_wr;
  reg_idx_e           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damp_q  <= DAMP_W'(52429);
      shape_q <= 1'b0;
      edge_q  <= 1'b0;
      scale_q <= SCALE_W'(ONE_Q16);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DAMPING: damp_q  <= pwdata[DAMP_W-1:0];
        REG_SHAPE:   shape_q <= pwdata[0];
        REG_EDGE:    edge_q  <= pwdata[0];
        REG_SCALE:   scale_q <= pwdata[SCALE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DAMPING: prdata = 32'(damp_q);
      REG_SHAPE:   prdata = 32'(shape_q);
      REG_EDGE:    prdata = 32'(edge_q);
      REG_SCALE:   prdata = 32'(scale_q);
    endcase
  end

  // no stage ever holds, so the input is always open
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // stage 0: capture the transfer
  // ---------------------------------------------------------------------
  logic                      v0_q;
  logic signed [FIELD_W-1:0] px0_q, py0_q, vx0_q, vy0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    px0_q <= pos_x_i;
    py0_q <= pos_y_i;
    vx0_q <= vel_x_i;
    vy0_q <= vel_y_i;
  end

  // ---------------------------------------------------------------------
  // stage 1: center offsets, squares, rectangle damping products
  // ---------------------------------------------------------------------
  localparam logic signed [DELTA_W-1:0] HALF_D = DELTA_W'(HALF_Q16);
  localparam int RV_W = DELTA_W + DAMP_W + 1;

  logic signed [DELTA_W-1:0]   dx1_d, dy1_d, nvx1, nvy1;
  logic signed [2*DELTA_W-1:0] dxx1, dyy1;
  logic signed [RV_W-1:0]      rvx1_d, rvy1_d;

  assign dx1_d  = $signed({px0_q[FIELD_W-1], px0_q}) - HALF_D;
  assign dy1_d  = $signed({py0_q[FIELD_W-1], py0_q}) - HALF_D;
  assign dxx1   = dx1_d * dx1_d;
  assign dyy1   = dy1_d * dy1_d;
  assign nvx1   = -$signed({vx0_q[FIELD_W-1], vx0_q});
  assign nvy1   = -$signed({vy0_q[FIELD_W-1], vy0_q});
  assign rvx1_d = nvx1 * $signed({1'b0, damp_q});
  assign rvy1_d = nvy1 * $signed({1'b0, damp_q});

  logic                      v1_q;
  logic signed [FIELD_W-1:0] px1_q, py1_q, vx1_q, vy1_q;
  logic signed [DELTA_W-1:0] dx1_q, dy1_q;
  logic [SQ_W-1:0]           sqx1_q, sqy1_q;
  logic [2*SCALE_W-1:0]      sc2_q;
  logic signed [RV_W-1:0]    rvx1_q, rvy1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px1_q  <= px0_q;
    py1_q  <= py0_q;
    vx1_q  <= vx0_q;
    vy1_q  <= vy0_q;
    dx1_q  <= dx1_d;
    dy1_q  <= dy1_d;
    sqx1_q <= dxx1[SQ_W-1:0];
    sqy1_q <= dyy1[SQ_W-1:0];
    sc2_q  <= scale_q * scale_q;
    rvx1_q <= rvx1_d;
    rvy1_q <= rvy1_d;
  end

  // ---------------------------------------------------------------------
  // stage 2: circle test and every result that needs no square root
  // ---------------------------------------------------------------------
  localparam logic signed [DELTA_W-1:0] ONE_D = DELTA_W'(ONE_Q16);

  logic [SUM_W-1:0]          sum2;
  logic                      outside2, in_x2, in_y2;
  logic signed [DELTA_W-1:0] mx2, my2;
  side_t                     side2_d;

  assign sum2     = SUM_W'(sqx1_q) + SUM_W'(sqy1_q);
  assign outside2 = {sum2, 2'b00} > (SUM_W + 2)'(sc2_q);
  assign in_x2    = !px1_q[FIELD_W-1] && (px1_q <= $signed(FIELD_W'(ONE_Q16)));
  assign in_y2    = !py1_q[FIELD_W-1] && (py1_q <= $signed(FIELD_W'(ONE_Q16)));
  assign mx2      = ONE_D - $signed({px1_q[FIELD_W-1], px1_q});
  assign my2      = ONE_D - $signed({py1_q[FIELD_W-1], py1_q});

  always_comb begin
    side2_d        = '0;
    side2_d.dx     = dx1_q;
    side2_d.dy     = dy1_q;
    side2_d.vx     = vx1_q;
    side2_d.vy     = vy1_q;
    side2_d.byp_px = px1_q;
    side2_d.byp_py = py1_q;
    side2_d.byp_vx = vx1_q;
    side2_d.byp_vy = vy1_q;
    if (shape_q == SHAPE_RECT) begin
      // each axis on its own: clamp and damp, or jump to the far edge
      if (!in_x2) begin
        if (edge_q == EDGE_WRAP) begin
          side2_d.byp_px = px1_q[FIELD_W-1] ? FIELD_W'(ONE_Q16) : '0;
        end else begin
          side2_d.byp_px = px1_q[FIELD_W-1] ? '0 : FIELD_W'(ONE_Q16);
          side2_d.byp_vx = sat20(rnd(64'(rvx1_q), 16));
        end
      end
      if (!in_y2) begin
        if (edge_q == EDGE_WRAP) begin
          side2_d.byp_py = py1_q[FIELD_W-1] ? FIELD_W'(ONE_Q16) : '0;
        end else begin
          side2_d.byp_py = py1_q[FIELD_W-1] ? '0 : FIELD_W'(ONE_Q16);
          side2_d.byp_vy = sat20(rnd(64'(rvy1_q), 16));
        end
      end
    end else if (outside2) begin
      if (edge_q == EDGE_WRAP) begin
        // mirror through the center
        side2_d.byp_px = sat20(64'(mx2));
        side2_d.byp_py = sat20(64'(my2));
      end else begin
        side2_d.refl = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // square root of sum * 2^16, one root bit per stage
  // ---------------------------------------------------------------------
  logic               sq_vld_q  [ROOT_W+1];
  side_t              sq_side_q [ROOT_W+1];
  logic [RAD_W-1:0]   sq_rad_q  [ROOT_W+1];
  logic [REM_W-1:0]   sq_rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0]  sq_root_q [ROOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else begin
      sq_vld_q[0] <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_side_q[0] <= side2_d;
    sq_rad_q[0]  <= RAD_W'({sum2, 16'b0});
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0] cat, trial;
    logic             ge;

    // bring down the next pair of radicand bits
    assign cat   = {sq_rem_q[k][REM_W-3:0], sq_rad_q[k][RAD_W-1 -: 2]};
    assign trial = {sq_root_q[k], 2'b01};
    assign ge    = cat >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k+1] <= 1'b0;
      end else begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_side_q[k+1] <= sq_side_q[k];
      sq_rad_q[k+1]  <= sq_rad_q[k] << 2;
      sq_rem_q[k+1]  <= ge ? cat - trial : cat;
      sq_root_q[k+1] <= {sq_root_q[k][ROOT_W-2:0], ge};
    end
  end

  // ---------------------------------------------------------------------
  // unit normal
  // ---------------------------------------------------------------------
  logic                     nv_vld;
  side_t                    nv_side;
  logic signed [NORM_W-1:0] nx, ny;

  pbe_norm_div u_norm_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sq_vld_q[ROOT_W]),
    .side_i   (sq_side_q[ROOT_W]),
    .root_i   (sq_root_q[ROOT_W]),
    .valid_o  (nv_vld),
    .side_o   (nv_side),
    .norm_x_o (nx),
    .norm_y_o (ny)
  );

  // ---------------------------------------------------------------------
  // p1: position and dot products
  // ---------------------------------------------------------------------
  localparam int PP_W  = NORM_W + SCALE_W + 1;
  localparam int VP_W  = FIELD_W + NORM_W;
  localparam int DOT_W = VP_W + 1;
  localparam int DH_W  = DOT_W - 20;
  localparam int PH_W  = DH_W + NORM_W;
  localparam int PL_W  = 21 + NORM_W;
  localparam int U_W   = 24;
  localparam int M_W   = U_W + DAMP_W + 1;

  logic                     p1_vld_q;
  side_t                    p1_side_q;
  logic signed [NORM_W-1:0] p1_nx_q, p1_ny_q;
  logic signed [PP_W-1:0]   p1_ppx_q, p1_ppy_q;
  logic signed [VP_W-1:0]   p1_vpx_q, p1_vpy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= nv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_side_q <= nv_side;
    p1_nx_q   <= nx;
    p1_ny_q   <= ny;
    p1_ppx_q  <= nx * $signed({1'b0, scale_q});
    p1_ppy_q  <= ny * $signed({1'b0, scale_q});
    p1_vpx_q  <= nv_side.vx * nx;
    p1_vpy_q  <= nv_side.vy * ny;
  end

  // ---------------------------------------------------------------------
  // p2: dot sum, projected position
  // ---------------------------------------------------------------------
  logic                      p2_vld_q;
  side_t                     p2_side_q;
  logic signed [NORM_W-1:0]  p2_nx_q, p2_ny_q;
  logic signed [DOT_W-1:0]   p2_dot_q;
  logic [FIELD_W-1:0]        p2_px_q, p2_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_side_q <= p1_side_q;
    p2_nx_q   <= p1_nx_q;
    p2_ny_q   <= p1_ny_q;
    p2_dot_q  <= DOT_W'(p1_vpx_q) + DOT_W'(p1_vpy_q);
    p2_px_q   <= sat20(64'sd32768 + rnd(64'(p1_ppx_q), 17));
    p2_py_q   <= sat20(64'sd32768 + rnd(64'(p1_ppy_q), 17));
  end

  // ---------------------------------------------------------------------
  // p3: dot times normal, split into two partial products
  // ---------------------------------------------------------------------
  logic signed [DH_W-1:0] dot_hi;
  logic signed [20:0]     dot_lo;

  assign dot_hi = p2_dot_q[DOT_W-1:20];
  assign dot_lo = $signed({1'b0, p2_dot_q[19:0]});

  logic                   p3_vld_q;
  side_t                  p3_side_q;
  logic [FIELD_W-1:0]     p3_px_q, p3_py_q;
  logic signed [PH_W-1:0] p3_phx_q, p3_phy_q;
  logic signed [PL_W-1:0] p3_plx_q, p3_ply_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_vld_q <= 1'b0;
    end else begin
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p3_side_q <= p2_side_q;
    p3_px_q   <= p2_px_q;
    p3_py_q   <= p2_py_q;
    p3_phx_q  <= dot_hi * p2_nx_q;
    p3_phy_q  <= dot_hi * p2_ny_q;
    p3_plx_q  <= dot_lo * p2_nx_q;
    p3_ply_q  <= dot_lo * p2_ny_q;
  end

  // ---------------------------------------------------------------------
  // p4: reflected velocity u = v - 2 (v.n) n
  // ---------------------------------------------------------------------
  logic signed [63:0] tx4, ty4, ux4, uy4;

  assign tx4 = (64'(p3_side_q.vx) <<< 32)
             - 2 * ((64'(p3_phx_q) <<< 20) + 64'(p3_plx_q));
  assign ty4 = (64'(p3_side_q.vy) <<< 32)
             - 2 * ((64'(p3_phy_q) <<< 20) + 64'(p3_ply_q));
  assign ux4 = rnd(tx4, 32);
  assign uy4 = rnd(ty4, 32);

  logic                  p4_vld_q;
  side_t                 p4_side_q;
  logic [FIELD_W-1:0]    p4_px_q, p4_py_q;
  logic signed [U_W-1:0] p4_ux_q, p4_uy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_vld_q <= 1'b0;
    end else begin
      p4_vld_q <= p3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p4_side_q <= p3_side_q;
    p4_px_q   <= p3_px_q;
    p4_py_q   <= p3_py_q;
    p4_ux_q   <= ux4[U_W-1:0];
    p4_uy_q   <= uy4[U_W-1:0];
  end

  // ---------------------------------------------------------------------
  // p5: damping
  // ---------------------------------------------------------------------
  logic                  p5_vld_q;
  side_t                 p5_side_q;
  logic [FIELD_W-1:0]    p5_px_q, p5_py_q;
  logic signed [M_W-1:0] p5_mx_q, p5_my_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_vld_q <= 1'b0;
    end else begin
      p5_vld_q <= p4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p5_side_q <= p4_side_q;
    p5_px_q   <= p4_px_q;
    p5_py_q   <= p4_py_q;
    p5_mx_q   <= p4_ux_q * $signed({1'b0, damp_q});
    p5_my_q   <= p4_uy_q * $signed({1'b0, damp_q});
  end

  // ---------------------------------------------------------------------
  // output register: pick circle reflection or the early result
  // ---------------------------------------------------------------------
  logic               out_vld_q;
  logic [FIELD_W-1:0] out_px_q, out_py_q, out_vx_q, out_vy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= p5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p5_side_q.refl) begin
      out_px_q <= p5_px_q;
      out_py_q <= p5_py_q;
      out_vx_q <= sat20(rnd(64'(p5_mx_q), 16));
      out_vy_q <= sat20(rnd(64'(p5_my_q), 16));
    end else begin
      out_px_q <= p5_side_q.byp_px;
      out_py_q <= p5_side_q.byp_py;
      out_vx_q <= p5_side_q.byp_vx;
      out_vy_q <= p5_side_q.byp_vy;
    end
  end

  assign done_o      = out_vld_q;
  assign new_pos_x_o = out_px_q;
  assign new_pos_y_o = out_py_q;
  assign new_vel_x_o = out_vx_q;
  assign new_vel_y_o = out_vy_q;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  // a particle sent to the reflect path lies off center, so the root is nonzero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sq_vld_q[0] && sq_side_q[0].refl) |-> (sq_rad_q[0] != '0))
    else $error("reflect path entered with zero distance");

  // on the reflect path the normal never exceeds unit length in either axis
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nv_vld && nv_side.refl) |->
      ((nx <= 18'sd65536) && (nx >= -18'sd65536) &&
       (ny <= 18'sd65536) && (ny >= -18'sd65536)))
    else $error("normal out of unit range");

  // a scale write lands in the register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (cfg_idx == REG_SCALE)) |=> (scale_q == $past(pwdata[SCALE_W-1:0])))
    else $error("scale register write lost");

endmodule

### verif/tb_top.sv
// self-checking testbench for particle_boundary_enforce_core: directed table, then random
// particles under random boundary settings; uses pbe_pkg and the core itself
`timescale 1ns / 100ps

module tb_top;
  import pbe_pkg::*;

  localparam int  LATENCY   = 57;
  localparam int  SETTLE    = LATENCY + 8;   // cycles to let the pipeline empty
  localparam int  LIMIT     = 300000;        // watchdog, far beyond the slowest run
  localparam int  N_PHASES  = 10;
  localparam int  PHASE_LEN = 70;

  typedef struct packed {
    logic [FIELD_W-1:0] px;
    logic [FIELD_W-1:0] py;
    logic [FIELD_W-1:0] vx;
    logic [FIELD_W-1:0] vy;
  } particle_t;

  // one directed row: boundary setting, particle, optional typed-in answer
  typedef struct packed {
    logic [DAMP_W-1:0]  damp;
    logic               shape;
    logic               mode;
    logic [SCALE_W-1:0] scale;
    particle_t          part;
    logic               typed;
    particle_t          answer;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [FIELD_W-1:0] pos_x_i = '0, pos_y_i = '0, vel_x_i = '0, vel_y_i = '0;
  logic        done_o;
  logic [FIELD_W-1:0] new_pos_x_o, new_pos_y_o, new_vel_x_o, new_vel_y_o;

  // predictor's copy of the boundary registers
  logic [DAMP_W-1:0]  cur_damp;
  logic               cur_shape;
  logic               cur_mode;
  logic [SCALE_W-1:0] cur_scale;

  particle_t pending_q[$];      // corrected particles still to come out
  row_t      rows[$];
  int        mismatches = 0;
  int        unexpected = 0;
  int        cycles = 0;

  always #6 clk_i = ~clk_i;

  particle_boundary_enforce_core dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .pos_x_i, .pos_y_i, .vel_x_i, .vel_y_i,
    .done_o, .new_pos_x_o, .new_pos_y_o, .new_vel_x_o, .new_vel_y_o
  );

  // ---------------------------------------------------------------- predictor
  // floor((v + 2^(s-1)) / 2^s)
  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp20(input longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  // round(|a| / b), ties away from zero, sign of a
  function automatic longint div_away(input longint a, input longint b);
    longint mag, q;
    mag = (a < 0) ? -a : a;
    q = (mag + b / 2) / b;
    return (a < 0) ? -q : q;
  endfunction

  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // one axis against the unit square
  function automatic void square_axis(inout longint p, inout longint v);
    if (p >= 0 && p <= ONE_Q16) return;
    if (cur_mode != EDGE_WRAP) begin
      p = (p < 0) ? 0 : ONE_Q16;
      v = clamp20(round_shift(-v * longint'(cur_damp), 16));
    end else begin
      p = (p < 0) ? ONE_Q16 : 0;
    end
  endfunction

  function automatic particle_t enforce_boundary(input particle_t in);
    longint px, py, vx, vy, dx, dy, s, sc, d, nx, ny, dot, ux, uy;
    particle_t res;
    px = longint'(signed'(in.px));
    py = longint'(signed'(in.py));
    vx = longint'(signed'(in.vx));
    vy = longint'(signed'(in.vy));
    if (cur_shape == SHAPE_RECT) begin
      square_axis(px, vx);
      square_axis(py, vy);
    end else begin
      dx = px - HALF_Q16;
      dy = py - HALF_Q16;
      s  = dx * dx + dy * dy;
      sc = longint'(cur_scale);
      // outside the circle only
      if (4 * s > sc * sc) begin
        if (cur_mode == EDGE_WRAP) begin
          px = clamp20(ONE_Q16 - px);
          py = clamp20(ONE_Q16 - py);
        end else begin
          d   = longint'(root64(longint'(s) << 16));
          nx  = div_away(dx * (64'sd1 <<< 24), d);
          ny  = div_away(dy * (64'sd1 <<< 24), d);
          dot = vx * nx + vy * ny;
          ux  = round_shift(vx * (64'sd1 <<< 32) - 2 * dot * nx, 32);
          uy  = round_shift(vy * (64'sd1 <<< 32) - 2 * dot * ny, 32);
          px  = clamp20(HALF_Q16 + round_shift(nx * sc, 17));
          py  = clamp20(HALF_Q16 + round_shift(ny * sc, 17));
          vx  = clamp20(round_shift(ux * longint'(cur_damp), 16));
          vy  = clamp20(round_shift(uy * longint'(cur_damp), 16));
        end
      end
    end
    res.px = px[FIELD_W-1:0];
    res.py = py[FIELD_W-1:0];
    res.vx = vx[FIELD_W-1:0];
    res.vy = vy[FIELD_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- checker
  // done_o is a one-cycle strobe, sampled at the edge that ends its cycle
  always @(posedge clk_i) begin
    particle_t got, want;
    if (rst_ni && done_o) begin
      got = '{new_pos_x_o, new_pos_y_o, new_vel_x_o, new_vel_y_o};
      if (pending_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result %h %h %h %h", got.px, got.py, got.vx, got.vy);
      end else begin
        want = pending_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("mismatch: expected %h %h %h %h, got %h %h %h %h",
                     want.px, want.py, want.vx, want.vy,
                     got.px, got.py, got.vx, got.vy);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  // wait until the pipeline is empty; nothing in flight may see a register change
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic reg_write(input reg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_boundary(input logic [DAMP_W-1:0] damp, input logic shape,
                              input logic mode, input logic [SCALE_W-1:0] scale);
    drain();
    reg_write(REG_DAMPING, 32'(damp));
    reg_write(REG_SHAPE, 32'(shape));
    reg_write(REG_EDGE, 32'(mode));
    reg_write(REG_SCALE, 32'(scale));
    cur_damp = damp; cur_shape = shape; cur_mode = mode; cur_scale = scale;
  endtask

  // present one particle from the falling edge and hold it until transferred
  task automatic issue(input particle_t p, input logic typed, input particle_t answer);
    @(negedge clk_i);
    start = 1'b1;
    pos_x_i = p.px; pos_y_i = p.py; vel_x_i = p.vx; vel_y_i = p.vy;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(typed ? answer : enforce_boundary(p));
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  function automatic row_t mk(input logic [DAMP_W-1:0] damp, input logic shape,
                              input logic mode, input logic [SCALE_W-1:0] scale,
                              input int px, input int py, input int vx, input int vy,
                              input logic typed = 1'b0,
                              input int ax = 0, input int ay = 0,
                              input int bx = 0, input int by = 0);
    row_t r;
    r.damp = damp; r.shape = shape; r.mode = mode; r.scale = scale;
    r.part = '{px[19:0], py[19:0], vx[19:0], vy[19:0]};
    r.typed = typed;
    r.answer = '{ax[19:0], ay[19:0], bx[19:0], by[19:0]};
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] rand_pos();
    int v;
    case ($urandom_range(0, 3))
      0:       v = int'($urandom);                           // anywhere
      1:       v = int'($urandom_range(0, 65536));           // inside the square
      default: v = int'($urandom_range(0, 196608)) - 65536;  // near the boundary
    endcase
    return v[19:0];
  endfunction

  function automatic logic [FIELD_W-1:0] rand_vel();
    int v;
    if ($urandom_range(0, 1)) v = int'($urandom);
    else v = int'($urandom_range(0, 16384)) - 8192;
    return v[19:0];
  endfunction

  // ---------------------------------------------------------------- sequence
  initial begin
    row_t      r;
    particle_t p;
    int        burst;
    logic [DAMP_W-1:0]  damp;
    logic [SCALE_W-1:0] scale;

    cur_damp = 17'd52429; cur_shape = 1'b0; cur_mode = 1'b0; cur_scale = 18'd65536;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset setting: circle of radius 0.5, reflect
    rows.push_back(mk(17'd52429, 1'b0, 1'b0, 18'd65536, 32768, 32768, 1234, -1234,
                      1'b1, 32768, 32768, 1234, -1234));           // center, distance zero
    rows.push_back(mk(17'd52429, 1'b0, 1'b0, 18'd65536, 65536, 32768, 500, 700,
                      1'b1, 65536, 32768, 500, 700));              // exactly on the radius
    rows.push_back(mk(17'd52429, 1'b0, 1'b0, 18'd65536, 70000, 40000, 3000, -2000));
    rows.push_back(mk(17'd52429, 1'b0, 1'b0, 18'd65536, -524288, -524288, 524287, -524288));
    rows.push_back(mk(17'd52429, 1'b0, 1'b0, 18'd65536, 524287, -524288, -524288, 524287));
    // circle extremes of scale and damping
    rows.push_back(mk(17'd131071, 1'b0, 1'b0, 18'd262143, 524287, 524287, 524287, 524287));
    rows.push_back(mk(17'd131071, 1'b0, 1'b0, 18'd262143, 100000, 20000, -524288, 9000));
    rows.push_back(mk(17'd0, 1'b0, 1'b0, 18'd0, 32769, 32768, 524287, 524287));
    rows.push_back(mk(17'd0, 1'b0, 1'b0, 18'd0, 32768, 32768, 7, 9,
                      1'b1, 32768, 32768, 7, 9));                  // scale zero, center
    rows.push_back(mk(17'd65536, 1'b0, 1'b0, 18'd131072, 0, 131072, 65536, -65536));
    // circle mirror
    rows.push_back(mk(17'd65536, 1'b0, 1'b1, 18'd0, 0, 0, 11, -11,
                      1'b1, 65536, 65536, 11, -11));
    rows.push_back(mk(17'd65536, 1'b0, 1'b1, 18'd0, -524288, 524287, -524288, 524287,
                      1'b1, 524287, -458751, -524288, 524287));    // mirror saturates
    // square reflect
    rows.push_back(mk(17'd65536, 1'b1, 1'b0, 18'd65536, -524288, 524287, 1000, -524288,
                      1'b1, 0, 65536, -1000, 524287));             // negated velocity saturates
    rows.push_back(mk(17'd65536, 1'b1, 1'b0, 18'd65536, 0, 65536, 77, 88,
                      1'b1, 0, 65536, 77, 88));                    // on the edges, untouched
    rows.push_back(mk(17'd0, 1'b1, 1'b0, 18'd65536, -1, 65537, 524287, -524288,
                      1'b1, 0, 65536, 0, 0));                      // zero damping
    rows.push_back(mk(17'd131071, 1'b1, 1'b0, 18'd65536, 70000, -3, 300001, -77777));
    rows.push_back(mk(17'd52429, 1'b1, 1'b0, 18'd65536, 40000, -1, 12345, -12345));
    // square wrap
    rows.push_back(mk(17'd52429, 1'b1, 1'b1, 18'd65536, -1, 65537, 524287, -524288,
                      1'b1, 65536, 0, 524287, -524288));
    rows.push_back(mk(17'd52429, 1'b1, 1'b1, 18'd65536, 524287, -524288, 5, 6,
                      1'b1, 0, 65536, 5, 6));

    foreach (rows[i]) begin
      r = rows[i];
      if (r.damp != cur_damp || r.shape != cur_shape || r.mode != cur_mode ||
          r.scale != cur_scale) begin
        pause(1);
        set_boundary(r.damp, r.shape, r.mode, r.scale);
      end
      issue(r.part, r.typed, r.answer);
    end

    // random phases, each under its own boundary setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0: damp = 17'd0;
        1: damp = 17'd65536;
        2: damp = 17'd131071;
        3: damp = 17'd52429;
        default: damp = 17'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: scale = 18'd0;
        1: scale = 18'd131072;
        2: scale = 18'd262143;
        3: scale = 18'd65536;
        default: scale = 18'($urandom);
      endcase
      pause(1);
      set_boundary(damp, ph[0], ph[1], scale);
      burst = 0;
      for (int n = 0; n < PHASE_LEN; n++) begin
        p = '{rand_pos(), rand_pos(), rand_vel(), rand_vel()};
        issue(p, 1'b0, '0);
        // bursts of random length, some of them long and back to back
        if (burst == 0) begin
          burst = (ph == 3) ? PHASE_LEN : $urandom_range(1, 20);
          pause($urandom_range(0, 8));
        end else begin
          burst--;
        end
      end
    end

    pause(1);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && unexpected == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pbe_pkg.sv
hw/rtl/pbe_norm_div.sv
hw/rtl/particle_boundary_enforce_core.sv
verif/tb_top.sv
